[rtl/sse_pkg.sv]
// ----------------------------------------------------------------------------
// sse_pkg
// shared constants and types for the substring search engine
// ----------------------------------------------------------------------------
package sse_pkg;

    // needle capacity in bytes (one cell per byte)
    localparam int NEEDLE_MAX  = 64;
    // width of the haystack offset counter
    localparam int POS_WIDTH   = 32;
    // needle length counter, holds 0 .. NEEDLE_MAX
    localparam int LEN_WIDTH   = $clog2(NEEDLE_MAX + 1);
    // width used to compare and subtract offset and length
    localparam int CMP_WIDTH   = (POS_WIDTH > LEN_WIDTH) ? POS_WIDTH : LEN_WIDTH;

    localparam int BYTE_WIDTH  = 8;
    localparam int START_WIDTH = 32;
    // found, match_start, needle_error padded to whole bytes
    localparam int OUT_WIDTH   = ((START_WIDTH + 2 + 7) / 8) * 8;

    // beat kind carried on tuser
    localparam logic KIND_NEEDLE   = 1'b0;
    localparam logic KIND_HAYSTACK = 1'b1;

    // shift controls broadcast to every cell of the chain
    typedef struct packed {
        logic win_shift;  // haystack byte shifts into the window
        logic ndl_shift;  // needle byte shifts into the needle row
        logic act_clear;  // drop all active marks (new search)
    } sse_ctrl_t;

endpackage

[rtl/sse_cell.sv]
// ----------------------------------------------------------------------------
// sse_cell
// one byte position: window byte, aligned needle byte and active mark
// ----------------------------------------------------------------------------
module sse_cell
    import sse_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sse_ctrl_t             ctrl,
    input  logic [BYTE_WIDTH-1:0] win_in,   // byte from the right neighbor
    input  logic [BYTE_WIDTH-1:0] ndl_in,
    input  logic                  act_in,
    output logic [BYTE_WIDTH-1:0] win_out,
    output logic [BYTE_WIDTH-1:0] ndl_out,
    output logic                  act_out,
    output logic                  hit       // window byte after shift matches
);

    logic [BYTE_WIDTH-1:0] win_reg;
    logic [BYTE_WIDTH-1:0] ndl_reg;
    logic                  act_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.win_shift) begin
            win_reg <= win_in;
        end
        if (ctrl.ndl_shift) begin
            ndl_reg <= ndl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg <= 1'b0;
        end else if (ctrl.ndl_shift) begin
            act_reg <= act_in;
        end else if (ctrl.act_clear) begin
            act_reg <= 1'b0;
        end
    end

    // compare against the byte this cell takes on the current shift
    assign hit     = !act_reg || (win_in == ndl_reg);
    assign win_out = win_reg;
    assign ndl_out = ndl_reg;
    assign act_out = act_reg;

endmodule

[rtl/sse_chain.sv]
// ----------------------------------------------------------------------------
// sse_chain
// row of cells, newest byte enters at the high end
// ----------------------------------------------------------------------------
module sse_chain
    import sse_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sse_ctrl_t             ctrl,
    input  logic [BYTE_WIDTH-1:0] byte_in,
    output logic                  all_hit
);

    logic [BYTE_WIDTH-1:0] win_q  [NEEDLE_MAX];
    logic [BYTE_WIDTH-1:0] ndl_q  [NEEDLE_MAX];
    logic [BYTE_WIDTH-1:0] win_in [NEEDLE_MAX];
    logic [BYTE_WIDTH-1:0] ndl_in [NEEDLE_MAX];
    logic [NEEDLE_MAX-1:0] act_q;
    logic [NEEDLE_MAX-1:0] act_in;
    logic [NEEDLE_MAX-1:0] hit;

    for (genvar j = 0; j < NEEDLE_MAX; j++) begin : g_cell
        if (j == NEEDLE_MAX - 1) begin : g_head
            assign win_in[j] = byte_in;
            assign ndl_in[j] = byte_in;
            assign act_in[j] = 1'b1;
        end else begin : g_body
            assign win_in[j] = win_q[j+1];
            assign ndl_in[j] = ndl_q[j+1];
            // a restart drops the marks of the old needle
            assign act_in[j] = act_q[j+1] && !ctrl.act_clear;
        end

        sse_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl),
            .win_in  (win_in[j]),
            .ndl_in  (ndl_in[j]),
            .act_in  (act_in[j]),
            .win_out (win_q[j]),
            .ndl_out (ndl_q[j]),
            .act_out (act_q[j]),
            .hit     (hit[j])
        );
    end

    assign all_hit = &hit;

endmodule

[rtl/substring_search_engine_core.sv]
// ----------------------------------------------------------------------------
// substring_search_engine_core
// first occurrence of a needle in a haystack byte stream
// ----------------------------------------------------------------------------
// latency: the result beat is valid the cycle after the last haystack beat
// throughput: one needle or haystack beat per cycle, set by the combinational
//   compare across the cell chain (each cell holds one window byte and one
//   aligned needle byte, all cells compare in parallel on every haystack beat);
//   input stalls only while a result beat waits for m_tready
// reset: aresetn synchronous active low, clears search state and output valid;
//   window and needle bytes are payload and only read after being written
// ----------------------------------------------------------------------------
module substring_search_engine_core
    import sse_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // input beats
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [BYTE_WIDTH-1:0] s_tdata,   // [7:0] data_byte
    input  logic                  s_tuser,   // [0] kind
    input  logic                  s_tlast,   // last byte of needle or haystack
    // result beats
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_WIDTH-1:0]  m_tdata    // [0] found, [32:1] match_start,
                                             // [33] needle_error, rest zero
);

    // search state
    logic [LEN_WIDTH-1:0]   len_reg,      len_next;
    logic                   ovf_reg,      ovf_next;
    logic                   done_reg,     done_next;
    logic [POS_WIDTH-1:0]   hay_pos_reg,  hay_pos_next;
    logic                   found_reg,    found_next;
    logic [POS_WIDTH-1:0]   pos_reg,      pos_next;

    // output register
    logic                   out_valid_reg,  out_valid_next;
    logic                   out_found_reg,  out_found_next;
    logic [START_WIDTH-1:0] out_start_reg,  out_start_next;
    logic                   out_err_reg,    out_err_next;

    logic                   s_fire;
    logic                   is_hay;
    logic                   restart;
    logic [LEN_WIDTH-1:0]   len_eff;
    logic                   ovf_eff;
    logic [POS_WIDTH-1:0]   hay_pos_inc;
    logic [CMP_WIDTH-1:0]   pos_ext;
    logic [CMP_WIDTH-1:0]   len_ext;
    logic                   match_now;
    logic                   found_now;
    logic [POS_WIDTH-1:0]   pos_now;
    logic                   all_hit;
    sse_ctrl_t              ctrl;

    // output stage frees up when the waiting result is taken
    assign s_tready = !out_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign is_hay   = (s_tuser == KIND_HAYSTACK);

    // a needle beat after a closed needle starts a fresh search
    assign restart  = !is_hay && done_reg;
    assign len_eff  = restart ? '0 : len_reg;
    assign ovf_eff  = restart ? 1'b0 : ovf_reg;

    // saturating haystack byte count, including this beat
    assign hay_pos_inc = (hay_pos_reg == '1) ? hay_pos_reg
                                             : hay_pos_reg + POS_WIDTH'(1);
    assign pos_ext     = CMP_WIDTH'(hay_pos_inc);
    assign len_ext     = CMP_WIDTH'(len_reg);

    // full match on the window as it stands after this byte shifts in
    assign match_now = !found_reg && !ovf_reg && (len_reg != '0) &&
                       (pos_ext >= len_ext) && all_hit;
    assign found_now = found_reg || match_now;
    assign pos_now   = match_now ? POS_WIDTH'(pos_ext - len_ext) : pos_reg;

    // shift controls for the cell chain
    always_comb begin
        ctrl           = '0;
        if (s_fire) begin
            if (is_hay) begin
                ctrl.win_shift = 1'b1;
                // end of search drops the needle marks
                ctrl.act_clear = s_tlast;
            end else begin
                ctrl.ndl_shift = (len_eff < LEN_WIDTH'(NEEDLE_MAX));
                ctrl.act_clear = restart;
            end
        end
    end

    sse_chain u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .byte_in (s_tdata),
        .all_hit (all_hit)
    );

    // next state of the search
    always_comb begin
        len_next     = len_reg;
        ovf_next     = ovf_reg;
        done_next    = done_reg;
        hay_pos_next = hay_pos_reg;
        found_next   = found_reg;
        pos_next     = pos_reg;
        if (s_fire) begin
            if (!is_hay) begin
                // needle beat: store while room is left, else flag overflow
                if (len_eff < LEN_WIDTH'(NEEDLE_MAX)) begin
                    len_next = len_eff + LEN_WIDTH'(1);
                    ovf_next = ovf_eff;
                end else begin
                    len_next = len_eff;
                    ovf_next = 1'b1;
                end
                if (restart) begin
                    done_next    = 1'b0;
                    hay_pos_next = '0;
                    found_next   = 1'b0;
                    pos_next     = '0;
                end
                if (s_tlast) begin
                    done_next = 1'b1;
                end
            end else if (s_tlast) begin
                // last haystack beat: result goes out, search state clears
                len_next     = '0;
                ovf_next     = 1'b0;
                done_next    = 1'b0;
                hay_pos_next = '0;
                found_next   = 1'b0;
                pos_next     = '0;
            end else begin
                done_next    = 1'b1;
                hay_pos_next = hay_pos_inc;
                found_next   = found_now;
                pos_next     = pos_now;
            end
        end
    end

    // output register
    always_comb begin
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_start_next = out_start_reg;
        out_err_next   = out_err_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (s_fire && is_hay && s_tlast) begin
            out_valid_next = 1'b1;
            out_found_next = found_now;
            out_start_next = found_now ? START_WIDTH'(pos_now) : '0;
            out_err_next   = ovf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            done_reg      <= 1'b0;
            hay_pos_reg   <= '0;
            found_reg     <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            done_reg      <= done_next;
            hay_pos_reg   <= hay_pos_next;
            found_reg     <= found_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        out_found_reg <= out_found_next;
        out_start_reg <= out_start_next;
        out_err_reg   <= out_err_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_WIDTH - START_WIDTH - 2)'(0), out_err_reg, out_start_reg,
                       out_found_reg};

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the substring search engine core
// ----------------------------------------------------------------------------
// drives needle and haystack beats (directed corner cases, then random
// searches with mostly well-formed needle/haystack pairs and some broken
// ones), keeps its own first-match tracker and checks every result beat
// field by field against the oldest predicted result
// ----------------------------------------------------------------------------
module tb;
    import sse_pkg::*;

    localparam int BEAT_TARGET   = 1300;
    localparam int CYCLE_LIMIT   = 200000;

    typedef logic [BYTE_WIDTH-1:0] byte_t;

    typedef struct packed {
        logic                   found;
        logic [START_WIDTH-1:0] start;
        logic                   err;
    } search_result_t;

    // tracks the search state and holds the results still owed by the core
    class search_tracker;
        byte_t              needle [NEEDLE_MAX];
        byte_t              recent [NEEDLE_MAX];  // newest byte at the top
        int unsigned        needle_len;
        bit                 overflow;
        bit                 closed;
        bit                 matched;
        bit [POS_WIDTH-1:0] hay_count;
        bit [POS_WIDTH-1:0] first_pos;
        search_result_t     pending_results[$];
        int                 predicted;
        int                 failures;

        function new();
            foreach (needle[i]) needle[i] = '0;
            predicted = 0;
            failures  = 0;
            restart();
        endfunction

        function void restart();
            needle_len = 0;
            overflow   = 1'b0;
            closed     = 1'b0;
            matched    = 1'b0;
            hay_count  = '0;
            first_pos  = '0;
            foreach (recent[i]) recent[i] = '0;
        endfunction

        function bit tail_matches();
            int unsigned base;
            base = NEEDLE_MAX - needle_len;
            for (int unsigned i = 0; i < needle_len; i++)
                if (recent[base + i] != needle[i]) return 1'b0;
            return 1'b1;
        endfunction

        // accepted input beat
        function void take_beat(logic kind, byte_t data, logic last);
            search_result_t res;
            if (kind == KIND_NEEDLE) begin
                if (closed) restart();
                if (needle_len < NEEDLE_MAX) begin
                    needle[needle_len] = data;
                    needle_len++;
                end else begin
                    overflow = 1'b1;
                end
                if (last) closed = 1'b1;
                return;
            end
            closed = 1'b1;
            for (int i = 0; i < NEEDLE_MAX - 1; i++) recent[i] = recent[i + 1];
            recent[NEEDLE_MAX - 1] = data;
            if (hay_count != '1) hay_count++;
            if (!matched && !overflow && needle_len > 0 &&
                hay_count >= needle_len && tail_matches()) begin
                matched   = 1'b1;
                first_pos = hay_count - needle_len;
            end
            if (!last) return;
            res.found = matched;
            res.start = matched ? START_WIDTH'(first_pos) : '0;
            res.err   = overflow;
            pending_results.push_back(res);
            predicted++;
            restart();
        endfunction

        // accepted result beat
        function void check_result(logic [OUT_WIDTH-1:0] beat);
            search_result_t exp_res;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual %h",
                         $time, beat);
                failures++;
                return;
            end
            exp_res = pending_results.pop_front();
            if (beat[0] !== exp_res.found) begin
                $display("%0t: found mismatch, expected %0d, actual %0d",
                         $time, exp_res.found, beat[0]);
                failures++;
            end
            if (beat[START_WIDTH:1] !== exp_res.start) begin
                $display("%0t: match_start mismatch, expected %0d, actual %0d",
                         $time, exp_res.start, beat[START_WIDTH:1]);
                failures++;
            end
            if (beat[START_WIDTH+1] !== exp_res.err) begin
                $display("%0t: needle_error mismatch, expected %0d, actual %0d",
                         $time, exp_res.err, beat[START_WIDTH+1]);
                failures++;
            end
            if (beat[OUT_WIDTH-1:START_WIDTH+2] !== '0) begin
                $display("%0t: padding mismatch, expected 0, actual %h",
                         $time, beat[OUT_WIDTH-1:START_WIDTH+2]);
                failures++;
            end
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    byte_t                s_tdata  = '0;
    logic                 s_tuser  = KIND_NEEDLE;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_WIDTH-1:0] m_tdata;

    search_tracker tracker;
    int            tx_idle_pct = 0;
    int            rx_idle_pct = 0;
    int            rx_hold     = 0;
    int            beats_sent  = 0;
    int            cycles      = 0;

    substring_search_engine_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[substring_search_engine_core] ERROR");
            $finish;
        end
    end

    // result side back-pressure in random bursts
    always @(posedge aclk) begin
        if (rx_hold != 0) begin
            rx_hold  <= rx_hold - 1;
            m_tready <= 1'b0;
        end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
            rx_hold  <= $urandom_range(0, 6);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // both handshakes observed with pre-edge values
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) tracker.take_beat(s_tuser, s_tdata, s_tlast);
        if (aresetn && m_tvalid && m_tready) tracker.check_result(m_tdata);
    end

    // one input beat, optionally preceded by an idle burst
    task automatic send_beat(input logic kind, input byte_t data, input logic last);
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        beats_sent++;
    endtask

    // two-letter alphabet provokes partial and overlapping matches
    function automatic byte_t pick_byte(bit narrow);
        if (narrow) return $urandom_range(0, 1) ? 8'h61 : 8'h62;
        return byte_t'($urandom_range(0, 255));
    endfunction

    task automatic random_search(input int idx, input bit tidy);
        byte_t pat[$];
        byte_t hay[$];
        int    nlen;
        int    hlen;
        int    sel;
        int    at;
        int    shape;
        bit    narrow;
        sel = $urandom_range(0, 99);
        if (idx == 0)      nlen = NEEDLE_MAX + $urandom_range(1, 8);
        else if (idx == 1) nlen = NEEDLE_MAX;
        else if (sel < 8)  nlen = 0;
        else if (sel < 78) nlen = $urandom_range(1, 6);
        else if (sel < 88) nlen = $urandom_range(7, NEEDLE_MAX - 1);
        else if (sel < 94) nlen = NEEDLE_MAX;
        else               nlen = NEEDLE_MAX + $urandom_range(1, 8);
        narrow = $urandom_range(0, 1);
        for (int i = 0; i < nlen; i++) pat.push_back(pick_byte(narrow));
        if (nlen > 20 && $urandom_range(0, 1)) hlen = nlen + $urandom_range(0, 8);
        else                                   hlen = $urandom_range(1, 30);
        for (int i = 0; i < hlen; i++) hay.push_back(pick_byte(narrow));
        // plant the needle somewhere in the haystack
        if (nlen > 0 && nlen <= hlen && $urandom_range(0, 99) < 60) begin
            at = $urandom_range(0, hlen - nlen);
            for (int i = 0; i < nlen; i++) hay[at + i] = pat[i];
        end
        // 0..79 well formed, then open needle, open needle with aborted haystack, stray needle beats
        shape = tidy ? 0 : $urandom_range(0, 99);
        if (shape >= 90)
            repeat ($urandom_range(1, 3))
                send_beat(KIND_NEEDLE, pick_byte(1'b0), logic'($urandom_range(0, 1)));
        for (int i = 0; i < nlen; i++)
            send_beat(KIND_NEEDLE, pat[i], (shape < 80 || shape >= 90) && i == nlen - 1);
        if (shape >= 85 && shape < 90) hlen = $urandom_range(1, hlen);
        for (int i = 0; i < hlen; i++)
            send_beat(KIND_HAYSTACK, hay[i],
                      (shape < 85 || shape >= 90) && i == hlen - 1);
    endtask

    initial begin
        tracker = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        tx_idle_pct = 30;
        rx_idle_pct = 30;
        // haystack with no needle loaded
        send_beat(KIND_HAYSTACK, 8'h00, 1'b1);
        // extreme bytes, match one byte in
        send_beat(KIND_NEEDLE, 8'hFF, 1'b0);
        send_beat(KIND_NEEDLE, 8'h00, 1'b1);
        send_beat(KIND_HAYSTACK, 8'h12, 1'b0);
        send_beat(KIND_HAYSTACK, 8'hFF, 1'b0);
        send_beat(KIND_HAYSTACK, 8'h00, 1'b1);
        // needle longer than haystack
        send_beat(KIND_NEEDLE, 8'h61, 1'b0);
        send_beat(KIND_NEEDLE, 8'h62, 1'b1);
        send_beat(KIND_HAYSTACK, 8'h61, 1'b1);
        // needle left open, first haystack beat closes it
        send_beat(KIND_NEEDLE, 8'h55, 1'b0);
        send_beat(KIND_HAYSTACK, 8'h55, 1'b1);
        // needle beat after a closed needle starts a new search
        send_beat(KIND_NEEDLE, 8'h11, 1'b1);
        send_beat(KIND_NEEDLE, 8'h22, 1'b1);
        send_beat(KIND_HAYSTACK, 8'h11, 1'b0);
        send_beat(KIND_HAYSTACK, 8'h22, 1'b1);
        // repeated occurrence keeps the first offset
        send_beat(KIND_NEEDLE, 8'h61, 1'b1);
        send_beat(KIND_HAYSTACK, 8'h61, 1'b0);
        send_beat(KIND_HAYSTACK, 8'h61, 1'b1);

        for (int idx = 0; beats_sent < BEAT_TARGET; idx++) begin
            if (beats_sent > BEAT_TARGET - 200) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else begin
                tx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
                rx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
            end
            random_search(idx, 1'b0);
        end
        // close out any broken search so the run ends on a result
        random_search(2, 1'b1);
        s_tvalid <= 1'b0;

        while (tracker.pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (tracker.failures == 0 && tracker.pending_results.size() == 0) begin
            $display("[substring_search_engine_core] OK");
        end else begin
            $display("[substring_search_engine_core] ERROR");
        end
        $finish;
    end

endmodule
